[hw/rtl/fosd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fosd_pkg;

  // sample format
  localparam int SAMPLE_BITS = 32;
  localparam int RESULT_BITS = 32;

  // stencil datapath widths
  localparam int OP_BITS   = SAMPLE_BITS + 1;   // holds a negated ghost sample
  localparam int SUM_BITS  = SAMPLE_BITS + 5;   // weighted stencil sum, signed
  localparam int MAG_BITS  = SAMPLE_BITS + 4;   // magnitude of the sum
  localparam int LIMB_BITS = 32;
  localparam int LIMBS     = (MAG_BITS + LIMB_BITS - 1) / LIMB_BITS;
  localparam int MAG_PAD   = LIMBS * LIMB_BITS;
  localparam int ACC_BITS  = MAG_PAD + LIMB_BITS;
  localparam int LIMB_CNT_BITS = (LIMBS > 1) ? $clog2(LIMBS) : 1;

  // divide by 12 * 65536 = 3 * 2^18, rounding half away from zero on magnitude
  localparam int              FRAC_SHIFT   = 18;
  localparam logic [18:0]     ROUND_BIAS   = 19'd393216;
  localparam logic [33:0]     SAT_LIMIT    = 34'd6442450944;   // 3 * 2^31
  localparam int              QUOT_IN_BITS = 33;
  localparam int              QUOT_BITS    = 31;
  localparam logic [33:0]     DIV3_MULT    = 34'h2_AAAA_AAAB;  // (2^35 + 1) / 3
  localparam int              DIV3_SHIFT   = 35;
  localparam int              DPROD_BITS   = QUOT_IN_BITS + 34;

  // job queue
  localparam int QUEUE_DEPTH = 4;

  // configuration registers
  localparam int          ADDR_BITS    = 3;
  localparam int          REG_IDX_BITS = ADDR_BITS - 2;
  localparam logic [REG_IDX_BITS-1:0] REG_INV_SPACING = 1'b0;
  localparam logic [REG_IDX_BITS-1:0] REG_ODD_PARITY  = 1'b1;
  localparam logic [31:0] INV_SPACING_RESET = 32'd6553600;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          final_sample;
  } in_t;

  typedef struct packed {
    logic signed [RESULT_BITS-1:0] derivative;
    logic                          run_end;
    logic                          short_run;
  } out_t;

  // one unit of work for the back end
  typedef struct packed {
    logic                      is_zero;
    logic                      run_end;
    logic                      short_run;
    logic signed [OP_BITS-1:0] ym2;
    logic signed [OP_BITS-1:0] ym1;
    logic signed [OP_BITS-1:0] yp1;
    logic signed [OP_BITS-1:0] yp2;
  } job_t;

endpackage

`default_nettype wire

[hw/rtl/fosd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module fosd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full    = (count == CNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fosd_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module fosd_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire fosd_pkg::in_t  in_data,
  input  wire logic           odd_parity,
  output logic                push,
  output fosd_pkg::job_t      job,
  input  wire logic           full
);

  localparam logic F_IDLE = 1'b0;
  localparam logic F_EMIT = 1'b1;

  localparam logic [1:0] PHASE_A = 2'd0;   // interior or inner-edge point
  localparam logic [1:0] PHASE_B = 2'd1;   // second-to-last point
  localparam logic [1:0] PHASE_Z = 2'd2;   // last point, always zero

  localparam int OPB = fosd_pkg::OP_BITS;

  logic        state;
  logic        state_next;
  logic [1:0]  phase;
  logic [2:0]  seen;
  logic        hold_fin;
  logic signed [fosd_pkg::SAMPLE_BITS-1:0] hold_y;
  logic signed [fosd_pkg::SAMPLE_BITS-1:0] window [4];

  logic signed [OPB-1:0] y_x;
  logic signed [OPB-1:0] w0_x;
  logic signed [OPB-1:0] w1_x;
  logic signed [OPB-1:0] w2_x;
  logic signed [OPB-1:0] w3_x;
  logic signed [OPB-1:0] y_m;
  logic signed [OPB-1:0] w0_m;
  logic signed [OPB-1:0] w1_m;
  logic        short_case;
  logic        present;
  logic        advance;
  logic        last;

  assign in_ready = (state == F_IDLE);

  // sign extension and mirrored ghosts
  assign y_x  = OPB'(hold_y);
  assign w0_x = OPB'(window[0]);
  assign w1_x = OPB'(window[1]);
  assign w2_x = OPB'(window[2]);
  assign w3_x = OPB'(window[3]);
  assign y_m  = odd_parity ? -y_x  : y_x;
  assign w0_m = odd_parity ? -w0_x : w0_x;
  assign w1_m = odd_parity ? -w1_x : w1_x;

  assign short_case = (seen < 3'd3) && hold_fin;

  // job for the current phase
  always_comb begin
    present = 1'b0;
    job     = '0;
    case (phase)
      PHASE_A: begin
        if (short_case) begin
          present       = 1'b1;
          job.is_zero   = 1'b1;
          job.run_end   = 1'b1;
          job.short_run = 1'b1;
        end else if (seen >= 3'd2) begin
          present = 1'b1;
          case (seen)
            3'd2: begin
              job.ym2 = y_m;
              job.ym1 = w0_m;
              job.yp1 = w0_x;
              job.yp2 = y_x;
            end
            3'd3: begin
              job.ym2 = w1_m;
              job.ym1 = w2_x;
              job.yp1 = w0_x;
              job.yp2 = y_x;
            end
            default: begin
              job.ym2 = w3_x;
              job.ym1 = w2_x;
              job.yp1 = w0_x;
              job.yp2 = y_x;
            end
          endcase
        end
      end
      PHASE_B: begin
        present = hold_fin;
        job.ym2 = w2_x;
        job.ym1 = w1_x;
        job.yp1 = y_x;
        job.yp2 = y_x;
      end
      PHASE_Z: begin
        present     = hold_fin;
        job.is_zero = 1'b1;
        job.run_end = 1'b1;
      end
      default: begin
        present = 1'b0;
      end
    endcase
  end

  assign push    = (state == F_EMIT) && present && !full;
  assign advance = (state == F_EMIT) && (!present || !full);
  assign last    = short_case || (!hold_fin && (phase == PHASE_A)) || (phase == PHASE_Z);

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (in_valid) begin
          state_next = F_EMIT;
        end
      end
      F_EMIT: begin
        if (advance && last) begin
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      phase <= PHASE_A;
      seen  <= '0;
    end else begin
      state <= state_next;
      if (state == F_IDLE) begin
        phase <= PHASE_A;
      end else if (advance) begin
        phase <= phase + 2'd1;
        if (last) begin
          if (hold_fin) begin
            seen <= '0;
          end else if (seen < 3'd4) begin
            seen <= seen + 3'd1;
          end
        end
      end
    end
  end

  // held sample and sample window
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        window[i] <= '0;
      end
    end else if (advance && last) begin
      if (hold_fin) begin
        for (int i = 0; i < 4; i++) begin
          window[i] <= '0;
        end
      end else begin
        window[3] <= window[2];
        window[2] <= window[1];
        window[1] <= window[0];
        window[0] <= hold_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_y   <= in_data.sample;
      hold_fin <= in_data.final_sample;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fosd_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module fosd_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           empty,
  input  wire fosd_pkg::job_t job,
  output logic                pop,
  input  wire logic [31:0]    inv_spacing,
  output logic                out_valid,
  input  wire logic           out_ready,
  output fosd_pkg::out_t      out_data
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_DIFF = 3'd1;
  localparam logic [2:0] B_SUM  = 3'd2;
  localparam logic [2:0] B_MUL  = 3'd3;
  localparam logic [2:0] B_RND  = 3'd4;
  localparam logic [2:0] B_DIV  = 3'd5;
  localparam logic [2:0] B_FIN  = 3'd6;

  localparam int SB  = fosd_pkg::SUM_BITS;
  localparam int LB  = fosd_pkg::LIMB_BITS;
  localparam int AB  = fosd_pkg::ACC_BITS;
  localparam int MP  = fosd_pkg::MAG_PAD;
  localparam int QB  = fosd_pkg::QUOT_BITS;
  localparam int QIB = fosd_pkg::QUOT_IN_BITS;
  localparam int CB  = fosd_pkg::LIMB_CNT_BITS;
  localparam int RB  = fosd_pkg::RESULT_BITS;

  logic [2:0]   state;
  logic [2:0]   state_next;
  logic [CB-1:0] limb_cnt;
  fosd_pkg::job_t cur;

  logic signed [SB-1:0] diff_a;
  logic signed [SB-1:0] diff_b;
  logic signed [SB-1:0] sum_s;
  logic [SB-1:0]        sum_abs;
  logic                 neg;
  logic [MP-1:0]        mag_sh;
  logic [AB-1:0]        acc;
  logic [2*LB-1:0]      limb_prod;
  logic [AB-1:0]        t_full;
  logic                 sat;
  logic [QIB-1:0]       t_low;
  logic [fosd_pkg::DPROD_BITS-1:0] dprod;
  logic [QB-1:0]        quot;
  logic [RB-1:0]        result;
  logic                 out_free;

  assign out_free = !out_valid || out_ready;
  assign pop      = (state == B_IDLE) && !empty;

  // stencil sum, one multiply per limb, rounding, divide by three
  assign sum_s     = diff_a + (diff_b <<< 3);
  assign sum_abs   = sum_s[SB-1] ? SB'(-sum_s) : SB'(sum_s);
  assign limb_prod = mag_sh[MP-1 -: LB] * inv_spacing;
  assign t_full    = (acc + AB'(fosd_pkg::ROUND_BIAS)) >> fosd_pkg::FRAC_SHIFT;
  assign dprod     = t_low * fosd_pkg::DIV3_MULT;

  // signed, saturated result
  always_comb begin
    if (cur.is_zero) begin
      result = '0;
    end else if (sat) begin
      result = neg ? {1'b1, {(RB-1){1'b0}}} : {1'b0, {(RB-1){1'b1}}};
    end else if (neg) begin
      result = -RB'(quot);
    end else begin
      result = RB'(quot);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!empty) begin
          state_next = job.is_zero ? B_FIN : B_DIFF;
        end
      end
      B_DIFF: state_next = B_SUM;
      B_SUM:  state_next = B_MUL;
      B_MUL: begin
        if (limb_cnt == CB'(fosd_pkg::LIMBS - 1)) begin
          state_next = B_RND;
        end
      end
      B_RND:  state_next = B_DIV;
      B_DIV:  state_next = B_FIN;
      B_FIN: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // sequencer and output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      limb_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_MUL) begin
        limb_cnt <= limb_cnt + 1'b1;
      end else begin
        limb_cnt <= '0;
      end
      if (state == B_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        cur <= job;
      end
      B_DIFF: begin
        diff_a <= SB'(cur.ym2) - SB'(cur.yp2);
        diff_b <= SB'(cur.yp1) - SB'(cur.ym1);
      end
      B_SUM: begin
        neg    <= sum_s[SB-1];
        mag_sh <= MP'(sum_abs[fosd_pkg::MAG_BITS-1:0]);
        acc    <= '0;
      end
      B_MUL: begin
        acc    <= (acc << LB) + AB'(limb_prod);
        mag_sh <= mag_sh << LB;
      end
      B_RND: begin
        sat   <= (t_full >= AB'(fosd_pkg::SAT_LIMIT));
        t_low <= t_full[QIB-1:0];
      end
      B_DIV: begin
        quot <= dprod[fosd_pkg::DIV3_SHIFT +: QB];
      end
      default: begin
      end
    endcase
    if (state == B_FIN && out_free) begin
      out_data.derivative <= result;
      out_data.run_end    <= cur.run_end;
      out_data.short_run  <= cur.short_run;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fourth_order_stencil_derivative.sv]
// the back end works on one job at a time, with the single 32x32 multiplier taking
//   one limb per cycle, then the rounding and divide-by-three stages
// the front accepts no new input item while it emits jobs; zero results skip the back end arithmetic
// reset: synchronous, clears control, sample window and sample count, loads register defaults
`timescale 1ns / 1ps
`default_nettype none

module fourth_order_stencil_derivative #(
  parameter int QUEUE_DEPTH = fosd_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire fosd_pkg::in_t                   in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output fosd_pkg::out_t                       out_data,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fosd_pkg::ADDR_BITS-1:0]  paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int JOB_BITS = $bits(fosd_pkg::job_t);

  logic [31:0]    inv_spacing;
  logic           odd_parity;
  logic           cfg_write;
  logic [fosd_pkg::REG_IDX_BITS-1:0] reg_idx;

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  fosd_pkg::job_t q_wr_job;
  fosd_pkg::job_t q_rd_job;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = paddr[fosd_pkg::ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_spacing <= fosd_pkg::INV_SPACING_RESET;
      odd_parity  <= 1'b0;
    end else if (cfg_write) begin
      case (reg_idx)
        fosd_pkg::REG_INV_SPACING: inv_spacing <= pwdata;
        fosd_pkg::REG_ODD_PARITY:  odd_parity  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fosd_pkg::REG_INV_SPACING: prdata = inv_spacing;
      fosd_pkg::REG_ODD_PARITY:  prdata = {31'b0, odd_parity};
      default:                   prdata = '0;
    endcase
  end

  // front: window, edge handling, job generation
  fosd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .odd_parity (odd_parity),
    .push       (q_push),
    .job        (q_wr_job),
    .full       (q_full)
  );

  // job queue between front and back
  fosd_queue #(
    .WIDTH (JOB_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_job),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_job),
    .empty   (q_empty)
  );

  // back: stencil arithmetic and output register
  fosd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (q_empty),
    .job         (q_rd_job),
    .pop         (q_pop),
    .inv_spacing (inv_spacing),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  // checks
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("job popped from an empty queue");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("front accepted a new item while emitting jobs");

  a_short_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.short_run) |-> (out_data.run_end && out_data.derivative == '0))
    else $error("short run result is not a zero end-of-run result");

endmodule

`default_nettype wire

[tb/sv/fourth_order_stencil_derivative_tb.sv]
`timescale 1ns / 1ps

module fourth_order_stencil_derivative_tb;

  // scoreboard: own copy of the stencil window and registers, expected results in order
  class derivative_scoreboard;
    localparam longint unsigned SCALE_DIV = 12 * 65536;

    logic [31:0]                             inv_spacing;
    logic                                    odd_parity;
    logic signed [fosd_pkg::SAMPLE_BITS-1:0] window [4];
    int unsigned                             seen_count;
    fosd_pkg::out_t                          pending_slopes [$];
    int unsigned                             mismatches;
    int unsigned                             checked;
    int unsigned                             samples;
    int unsigned                             runs;
    int unsigned                             short_runs;

    function new();
      mismatches = 0;
      checked    = 0;
      samples    = 0;
      runs       = 0;
      short_runs = 0;
      reset_state();
    endfunction

    function void clear_run();
      foreach (window[i]) window[i] = '0;
      seen_count = 0;
    endfunction

    function void reset_state();
      inv_spacing = fosd_pkg::INV_SPACING_RESET;
      odd_parity  = 1'b0;
      clear_run();
    endfunction

    function void set_register(input logic [fosd_pkg::REG_IDX_BITS-1:0] idx,
                               input logic [31:0] value);
      if (idx == fosd_pkg::REG_INV_SPACING) begin
        inv_spacing = value;
      end else if (idx == fosd_pkg::REG_ODD_PARITY) begin
        odd_parity = value[0];
      end
    endfunction

    // five-point sum, scaled by inv_spacing / (12 * 2^16), rounded half away, saturated
    function logic signed [fosd_pkg::RESULT_BITS-1:0] scaled_slope(
        input longint ym2, input longint ym1, input longint yp1, input longint yp2);
      longint      sum;
      logic [95:0] mag;
      logic [95:0] prod;
      logic [95:0] quot;
      logic [95:0] rem;
      sum  = ym2 - 8 * ym1 + 8 * yp1 - yp2;
      mag  = (sum < 0) ? 96'(-sum) : 96'(sum);
      prod = mag * inv_spacing;
      quot = prod / SCALE_DIV;
      rem  = prod % SCALE_DIV;
      if (2 * rem >= SCALE_DIV) quot = quot + 1;
      if (sum < 0) return (quot > 96'h7FFF_FFFF) ? 32'sh8000_0000 : -quot[31:0];
      return (quot > 96'h7FFF_FFFF) ? 32'sh7FFF_FFFF : quot[31:0];
    endfunction

    function void queue_slope(input logic signed [fosd_pkg::RESULT_BITS-1:0] d,
                              input logic last, input logic is_short);
      fosd_pkg::out_t r;
      r.derivative = d;
      r.run_end    = last;
      r.short_run  = is_short;
      pending_slopes.insert(pending_slopes.size(), r);
    endfunction

    // accepted input transfer: advance the window, queue what it releases
    function void note_input(input fosd_pkg::in_t item);
      longint y;
      longint p;
      longint w0;
      longint w1;
      longint w2;
      longint w3;
      y  = item.sample;
      p  = odd_parity ? -1 : 1;
      w0 = window[0];
      w1 = window[1];
      w2 = window[2];
      w3 = window[3];
      samples++;
      if (seen_count < 3 && item.final_sample) begin
        queue_slope('0, 1'b1, 1'b1);
        runs++;
        short_runs++;
        clear_run();
        return;
      end
      case (seen_count)
        2: queue_slope(scaled_slope(p * y, p * w0, w0, y), 1'b0, 1'b0);
        3: queue_slope(scaled_slope(p * w1, w2, w0, y), 1'b0, 1'b0);
        4: queue_slope(scaled_slope(w3, w2, w0, y), 1'b0, 1'b0);
        default: ;
      endcase
      if (item.final_sample) begin
        // outer edge: ghost repeats the last sample, last point is zero
        queue_slope(scaled_slope(w2, w1, y, y), 1'b0, 1'b0);
        queue_slope('0, 1'b1, 1'b0);
        runs++;
        clear_run();
        return;
      end
      window[3] = window[2];
      window[2] = window[1];
      window[1] = window[0];
      window[0] = item.sample;
      if (seen_count < 4) seen_count++;
    endfunction

    // accepted output transfer against the oldest expectation
    function void check_result(input fosd_pkg::out_t got);
      fosd_pkg::out_t want;
      if (pending_slopes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: derivative %0d run_end %b short_run %b",
                   got.derivative, got.run_end, got.short_run);
        return;
      end
      want = pending_slopes.pop_front();
      checked++;
      if (got.derivative !== want.derivative || got.run_end !== want.run_end ||
          got.short_run !== want.short_run) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: derivative exp %0d got %0d, run_end exp %b got %b, %s",
                   checked, want.derivative, got.derivative, want.run_end, got.run_end,
                   $sformatf("short_run exp %b got %b", want.short_run, got.short_run));
      end
    endfunction

    function int unsigned pending_count();
      return pending_slopes.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  fosd_pkg::in_t                  in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  fosd_pkg::out_t                 out_data;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [fosd_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [31:0]                    pwdata = '0;
  logic [31:0]                    prdata;
  logic                           pready;

  derivative_scoreboard board = new();
  bit                   quiet = 1'b0;
  int unsigned          settings = 0;
  logic [31:0]          script [$];

  fourth_order_stencil_derivative dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // output side: check each transfer, stall at random
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_data);
    out_ready <= !rst && (quiet || $urandom_range(99) >= 11);
  end

  // register write: setup cycle, then access cycle
  task automatic write_register(input logic [fosd_pkg::REG_IDX_BITS-1:0] idx,
                                input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_spacing_and_parity(input logic [31:0] inv, input logic parity);
    write_register(fosd_pkg::REG_INV_SPACING, inv);
    write_register(fosd_pkg::REG_ODD_PARITY, {31'b0, parity});
    settings++;
  endtask

  // one input transfer, with a random idle gap ahead of it
  task automatic send_item(input fosd_pkg::in_t item);
    if (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    board.note_input(item);
  endtask

  // send the scripted samples as one run
  task automatic play_script();
    fosd_pkg::in_t item;
    foreach (script[i]) begin
      item.sample       = script[i];
      item.final_sample = (i == script.size() - 1);
      send_item(item);
    end
  endtask

  // drop valid, wait for every expected result, then let the front end go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] small_sample();
    return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
  endfunction

  function automatic logic [31:0] pick_sample();
    int unsigned mode;
    mode = $urandom_range(9);
    if (mode < 4) return small_sample();
    if (mode < 8) return $urandom();
    case ($urandom_range(3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // one run: smooth curves in half the runs, otherwise noise, rarely alternating extremes
  task automatic send_run(input int len);
    fosd_pkg::in_t item;
    int unsigned   style;
    logic [31:0]   base;
    logic [31:0]   step;
    logic [31:0]   bend;
    style = $urandom_range(9);
    base  = small_sample();
    step  = $urandom_range(0, 32'h0001_FFFF) - 32'h0001_0000;
    bend  = $urandom_range(0, 32'h7FF) - 32'h400;
    for (int i = 0; i < len; i++) begin
      if (style < 5) item.sample = base + i * step + i * i * bend;
      else if (style < 9) item.sample = pick_sample();
      else item.sample = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
      item.final_sample = (i == len - 1);
      send_item(item);
    end
  endtask

  task automatic random_phase(input logic [31:0] inv, input logic parity, input bit calm,
                              input int items);
    int sent;
    int len;
    int unsigned roll;
    set_spacing_and_parity(inv, parity);
    quiet = calm;
    sent  = 0;
    while (sent < items) begin
      roll = $urandom_range(99);
      if (roll < 70) len = $urandom_range(4, 12);
      else if (roll < 90) len = $urandom_range(1, 3);
      else len = $urandom_range(13, 30);
      send_run(len);
      sent += len;
    end
    settle();
    quiet = 1'b0;
  endtask

  initial begin
    int unsigned failures;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    board.reset_state();
    settings = 1;

    // directed: short runs of one, two and three samples
    script = '{32'h7FFF_FFFF};
    play_script();
    script = '{32'h8000_0000, 32'h7FFF_FFFF};
    play_script();
    script = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
    play_script();
    // shortest full run, saturating both ways
    script = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    play_script();
    // linear ramp, slope of one per grid point
    script = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
               32'h0005_0000, 32'h0006_0000};
    play_script();
    settle();

    // odd parity with full-scale spacing: negated ghost of the most negative sample
    set_spacing_and_parity(32'hFFFF_FFFF, 1'b1);
    script = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    play_script();
    script = '{32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0005, 32'h0000_0002};
    play_script();
    settle();

    // zero spacing forces every result to zero
    set_spacing_and_parity(32'h0000_0000, 1'b0);
    script = '{32'h1234_5678, 32'hFEDC_BA98, 32'h7FFF_FFFF, 32'h8000_0000};
    play_script();
    settle();

    // random phases across register settings
    random_phase(32'h0001_0000, 1'b0, 1'b1, 30);
    random_phase(32'hFFFF_FFFF, 1'b1, 1'b0, 30);
    random_phase(32'h0000_0000, 1'b1, 1'b0, 25);
    random_phase($urandom(), 1'($urandom_range(1)), 1'b0, 30);
    random_phase(32'h0000_0001, 1'b0, 1'b0, 25);
    random_phase(fosd_pkg::INV_SPACING_RESET, 1'b1, 1'b0, 30);
    random_phase($urandom_range(32'h0000_1000, 32'h00FF_FFFF), 1'b0, 1'b0, 25);

    failures = board.mismatches + board.pending_count();
    $display("covered %0d samples in %0d runs (%0d short) under %0d register settings",
             board.samples, board.runs, board.short_runs, settings);
    $display("%0d results compared, %0d mismatches", board.checked, board.mismatches);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
